@@ rtl/pip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    // polygon capacity and coordinate width
    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;

    localparam int ADDR_BITS = $clog2(MAX_VERTICES);
    localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
    localparam int XY_BITS   = 2 * COORD_BITS;

    // edge arithmetic widths: relative coords, products, cross/dot sums
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // location codes
    localparam logic [1:0] LOC_OUTSIDE = 2'd0;
    localparam logic [1:0] LOC_ON      = 2'd1;
    localparam logic [1:0] LOC_INSIDE  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   command;
        logic   start_new;
        t_coord coord_x;
        t_coord coord_y;
    } t_in_word;

    typedef struct packed {
        logic       result_kind;
        logic [1:0] location;
        logic       vertex_dropped;
    } t_out_word;

    // one edge handed to the evaluator
    typedef struct packed {
        logic   vld;
        logic   last;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge_req;

    // verdict on one edge
    typedef struct packed {
        logic vld;
        logic last;
        logic on_edge;
        logic toggle;
    } t_edge_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

@@ rtl/pip_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/pip_edge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_edge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pip_pkg::t_edge_req i_edge,
    input  wire pip_pkg::t_coord    i_qx,
    input  wire pip_pkg::t_coord    i_qy,
    output      pip_pkg::t_edge_res o_res
);
    import pip_pkg::*;

    // stage 1: endpoints relative to the point, lower endpoint first
    logic signed [DIFF_W-1:0] s_ax, s_ay, s_bx, s_by;
    logic signed [DIFF_W-1:0] r_s1_ax, r_s1_ay, r_s1_bx, r_s1_by;
    logic                     r_s1_vld, r_s1_last;

    // stage 2: products
    logic signed [PROD_W-1:0] r_s2_axby, r_s2_bxay, r_s2_axbx, r_s2_ayby;
    logic                     r_s2_ay_le0, r_s2_by_gt0;
    logic                     r_s2_vld, r_s2_last;

    // stage 3: cross and dot
    logic signed [SUM_W-1:0] s_cross, s_dot;
    logic                    r_s3_vld, r_s3_last, r_s3_on, r_s3_toggle;

    always_comb begin
        s_ax = {i_edge.ax[COORD_BITS-1], i_edge.ax} - {i_qx[COORD_BITS-1], i_qx};
        s_ay = {i_edge.ay[COORD_BITS-1], i_edge.ay} - {i_qy[COORD_BITS-1], i_qy};
        s_bx = {i_edge.bx[COORD_BITS-1], i_edge.bx} - {i_qx[COORD_BITS-1], i_qx};
        s_by = {i_edge.by[COORD_BITS-1], i_edge.by} - {i_qy[COORD_BITS-1], i_qy};
    end

    always_ff @(posedge i_clk) begin
        if (s_ay > s_by) begin
            r_s1_ax <= s_bx;
            r_s1_ay <= s_by;
            r_s1_bx <= s_ax;
            r_s1_by <= s_ay;
        end else begin
            r_s1_ax <= s_ax;
            r_s1_ay <= s_ay;
            r_s1_bx <= s_bx;
            r_s1_by <= s_by;
        end
        r_s1_last <= i_edge.last;

        r_s2_axby   <= r_s1_ax * r_s1_by;
        r_s2_bxay   <= r_s1_bx * r_s1_ay;
        r_s2_axbx   <= r_s1_ax * r_s1_bx;
        r_s2_ayby   <= r_s1_ay * r_s1_by;
        r_s2_ay_le0 <= (r_s1_ay <= 0);
        r_s2_by_gt0 <= (r_s1_by > 0);
        r_s2_last   <= r_s1_last;
    end

    always_comb begin
        s_cross = {r_s2_axby[PROD_W-1], r_s2_axby} - {r_s2_bxay[PROD_W-1], r_s2_bxay};
        s_dot   = {r_s2_axbx[PROD_W-1], r_s2_axbx} + {r_s2_ayby[PROD_W-1], r_s2_ayby};
    end

    always_ff @(posedge i_clk) begin
        r_s3_last   <= r_s2_last;
        r_s3_on     <= (s_cross == 0) && (s_dot <= 0);
        // leftward ray crosses this edge
        r_s3_toggle <= r_s2_ay_le0 && r_s2_by_gt0 && (s_cross < 0);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_edge.vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_comb begin
        o_res.vld     = r_s3_vld;
        o_res.last    = r_s3_last;
        o_res.on_edge = r_s3_on;
        o_res.toggle  = r_s3_toggle;
    end

endmodule

`default_nettype wire

@@ rtl/point_in_polygon_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Point-in-polygon classifier. A word with command 0 appends one vertex
// (start_new empties the polygon first); it is written in the cycle it is
// taken and acknowledged on the next cycle, so busy stays low and loads may
// follow back to back. A vertex beyond the 256-entry capacity is not stored
// and is acknowledged with vertex_dropped set. A word with command 1
// classifies the point against the closed polygon as outside, on an edge or
// inside. A query reads the vertex memory one entry per cycle and feeds each
// edge, the closing edge last, into a three-stage edge evaluator; busy is
// high from the taking of the query until the answer strobes, and the next
// word can be taken once busy is low again. An empty polygon answers outside
// on the next cycle. Each answer is on the result port for one cycle only and
// must be captured then: there is no way to hold it.
module point_in_polygon_test (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire pip_pkg::t_in_word   i_word,
    output      logic                o_strobe,
    output      pip_pkg::t_out_word  o_word
);
    import pip_pkg::*;

    t_state r_state, n_state;

    logic                s_accept_q;
    logic                s_accept;
    logic                s_rd_issue;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] s_base;
    logic                s_store_ok;
    logic [CNT_BITS-1:0] r_rd_idx;
    logic                s_rd_at_last;
    logic                r_rd_vld, r_rd_first, r_rd_last;
    logic                r_close;
    logic [XY_BITS-1:0]  s_rdata;
    t_coord              s_dx, s_dy;
    t_coord              r_qx, r_qy;
    t_coord              r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                r_on, r_odd;
    logic                s_on_fin, s_odd_fin;
    t_edge_req           s_edge;
    t_edge_res           s_eres;
    t_out_word           r_out;
    logic                r_strobe;

    assign s_accept     = start && !busy;
    assign s_accept_q   = s_accept && (i_word.command == CMD_QUERY);
    assign s_rd_at_last = (r_rd_idx == CNT_BITS'(r_count - 1'b1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept_q && (r_count != '0)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (s_rd_at_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (s_eres.vld && s_eres.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy       = 1'b1;
        s_rd_issue = 1'b0;
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_WALK:  s_rd_issue = 1'b1;
            ST_DRAIN: s_rd_issue = 1'b0;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // vertex load: slot and overflow
    always_comb begin
        s_base     = i_word.start_new ? '0 : r_count;
        s_store_ok = (s_base < CNT_BITS'(MAX_VERTICES));
    end

    pip_ram #(
        .WIDTH (XY_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (s_accept && (i_word.command == CMD_LOAD) && s_store_ok),
        .i_waddr (s_base[ADDR_BITS-1:0]),
        .i_wdata ({i_word.coord_x, i_word.coord_y}),
        .i_raddr (r_rd_idx[ADDR_BITS-1:0]),
        .o_rdata (s_rdata)
    );

    assign s_dx = s_rdata[XY_BITS-1:COORD_BITS];
    assign s_dy = s_rdata[COORD_BITS-1:0];

    // control registers: count, read walk, tags aligned to read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_idx   <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_rd_last  <= 1'b0;
            r_close    <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (s_accept && (i_word.command == CMD_LOAD) && s_store_ok) begin
                r_count <= CNT_BITS'(s_base + 1'b1);
            end
            if (s_accept_q) begin
                r_rd_idx <= '0;
            end else if (s_rd_issue) begin
                r_rd_idx <= CNT_BITS'(r_rd_idx + 1'b1);
            end
            r_rd_vld   <= s_rd_issue;
            r_rd_first <= s_rd_issue && (r_rd_idx == '0);
            r_rd_last  <= s_rd_issue && s_rd_at_last;
            r_close    <= r_rd_vld && r_rd_last;
            // loads and empty-polygon queries answer at once, walks at the end
            r_strobe   <= (s_accept && ((i_word.command == CMD_LOAD) || (r_count == '0)))
                          || (s_eres.vld && s_eres.last);
        end
    end

    // point and vertex holding registers
    always_ff @(posedge i_clk) begin
        if (s_accept_q) begin
            r_qx <= i_word.coord_x;
            r_qy <= i_word.coord_y;
        end
        if (r_rd_vld) begin
            r_prev_x <= s_dx;
            r_prev_y <= s_dy;
            if (r_rd_first) begin
                r_first_x <= s_dx;
                r_first_y <= s_dy;
            end
        end
    end

    // edge feed: consecutive vertices, then the closing edge
    always_comb begin
        s_edge.vld  = (r_rd_vld && !r_rd_first) || r_close;
        s_edge.last = r_close;
        s_edge.ax   = r_prev_x;
        s_edge.ay   = r_prev_y;
        s_edge.bx   = r_close ? r_first_x : s_dx;
        s_edge.by   = r_close ? r_first_y : s_dy;
    end

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (s_edge),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_res   (s_eres)
    );

    // on-edge flag and crossing parity
    assign s_on_fin  = r_on || s_eres.on_edge;
    assign s_odd_fin = r_odd ^ s_eres.toggle;

    always_ff @(posedge i_clk) begin
        if (s_accept_q) begin
            r_on  <= 1'b0;
            r_odd <= 1'b0;
        end else if (s_eres.vld) begin
            r_on  <= s_on_fin;
            r_odd <= s_odd_fin;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (s_accept && (i_word.command == CMD_LOAD)) begin
            r_out.result_kind    <= KIND_LOAD;
            r_out.location       <= LOC_OUTSIDE;
            r_out.vertex_dropped <= !s_store_ok;
        end else if (s_accept_q && (r_count == '0)) begin
            // empty polygon
            r_out.result_kind    <= KIND_QUERY;
            r_out.location       <= LOC_OUTSIDE;
            r_out.vertex_dropped <= 1'b0;
        end else if (s_eres.vld && s_eres.last) begin
            r_out.result_kind    <= KIND_QUERY;
            r_out.location       <= s_on_fin  ? LOC_ON :
                                    s_odd_fin ? LOC_INSIDE : LOC_OUTSIDE;
            r_out.vertex_dropped <= 1'b0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

endmodule

`default_nettype wire

@@ rtl/pip_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire pip_pkg::t_in_word  i_word,
    input wire logic               o_strobe,
    input wire pip_pkg::t_out_word o_word
);
    import pip_pkg::*;

    // a load is acknowledged on the very next cycle
    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_word.command == CMD_LOAD))
        |=> (o_strobe && (o_word.result_kind == KIND_LOAD)))
        else $error("load word not acknowledged next cycle");

    // a query either starts a walk or answers at once
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_word.command == CMD_QUERY))
        |=> (busy || (o_strobe && (o_word.result_kind == KIND_QUERY))))
        else $error("query neither walked nor answered");

    // an answer only shows once the walk has ended
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while busy");

    // query answers carry a real location and no drop flag
    a_query_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_word.result_kind == KIND_QUERY))
        |-> (!o_word.vertex_dropped && ((o_word.location == LOC_OUTSIDE) ||
             (o_word.location == LOC_ON) || (o_word.location == LOC_INSIDE))))
        else $error("malformed query answer");

    // load acknowledges carry location outside
    a_load_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_word.result_kind == KIND_LOAD))
        |-> (o_word.location == LOC_OUTSIDE))
        else $error("load acknowledge with a location");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_word   (i_word),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pip_pkg::*;

    // how vertex and query coordinates are drawn for one polygon
    typedef enum int {
        FRAME_GRID,
        FRAME_COARSE,
        FRAME_WIDE
    } t_frame;

    // shadow polygon, crossing-number predictor and result checker
    class polygon_scoreboard;
        t_coord    vx [MAX_VERTICES];
        t_coord    vy [MAX_VERTICES];
        int        n_vert;
        t_out_word owed [$];
        int        n_bad;
        int        n_loads;
        int        n_dropped;
        int        n_queries;
        int        n_loc [3];

        function int pending();
            return owed.size();
        endfunction

        // walk every edge, closing edge included, relative to the point
        function logic [1:0] locate(t_coord qx, t_coord qy);
            logic signed [DIFF_W-1:0] ax, ay, bx, by, t;
            logic signed [SUM_W-1:0]  cr, dt;
            bit                       odd;
            int                       j;
            odd = 1'b0;
            for (int i = 0; i < n_vert; i++) begin
                j  = (i + 1 == n_vert) ? 0 : i + 1;
                ax = vx[i] - qx;
                ay = vy[i] - qy;
                bx = vx[j] - qx;
                by = vy[j] - qy;
                // lower endpoint first
                if (ay > by) begin
                    t = ax; ax = bx; bx = t;
                    t = ay; ay = by; by = t;
                end
                cr = ax * by - bx * ay;
                dt = ax * bx + ay * by;
                if (ay <= 0 && by > 0 && cr < 0)
                    odd = !odd;
                if (cr == 0 && dt <= 0)
                    return LOC_ON;
            end
            return odd ? LOC_INSIDE : LOC_OUTSIDE;
        endfunction

        // a word has been taken: update the shadow polygon, queue the answer
        function void note_word(t_in_word w);
            t_out_word want;
            want = '0;
            if (w.command == CMD_LOAD) begin
                want.result_kind = KIND_LOAD;
                want.location    = LOC_OUTSIDE;
                if (w.start_new)
                    n_vert = 0;
                if (n_vert < MAX_VERTICES) begin
                    vx[n_vert] = w.coord_x;
                    vy[n_vert] = w.coord_y;
                    n_vert++;
                end else begin
                    want.vertex_dropped = 1'b1;
                    n_dropped++;
                end
                n_loads++;
            end else begin
                want.result_kind = KIND_QUERY;
                want.location    = locate(w.coord_x, w.coord_y);
                n_queries++;
                n_loc[want.location]++;
            end
            owed = {owed, want};
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (owed.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: result kind=%0d loc=%0d drop=%0d with none pending",
                             $time, got.result_kind, got.location, got.vertex_dropped);
                return;
            end
            want = owed.pop_front();
            if (got.result_kind !== want.result_kind || got.location !== want.location ||
                got.vertex_dropped !== want.vertex_dropped) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: mismatch exp kind=%0d loc=%0d drop=%0d,",
                             $time, want.result_kind, want.location, want.vertex_dropped,
                             " got kind=%0d loc=%0d drop=%0d",
                             got.result_kind, got.location, got.vertex_dropped);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_word          i_word;
    logic              o_strobe;
    t_out_word         o_word;

    polygon_scoreboard sb = new();

    // stimulus state
    t_frame            frame_mode;
    int                frame_ox;
    int                frame_oy;
    int                poly_x [$];
    int                poly_y [$];
    bit                quiet;
    int                n_sent;

    point_in_polygon_test i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // note taken words and check results on the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_word(o_word);
            if (start && !busy)
                sb.note_word(i_word);
        end
    end

    // one coordinate in the current frame; span only matters on the grid
    function int frame_coord(int off, int span);
        case (frame_mode)
            FRAME_GRID:   return off + int'($urandom_range(0, 2 * span)) - span;
            FRAME_COARSE: return (int'($urandom_range(0, 14)) - 7) * 4681;
            default:      return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // offer one word, hold it until taken, then idle for a random gap
    task automatic send_word(logic cmd, logic fresh, int x, int y);
        t_in_word w;
        int       gap;
        w.command   = cmd;
        w.start_new = fresh;
        w.coord_x   = t_coord'(x);
        w.coord_y   = t_coord'(y);
        gap         = quiet ? 0 : $urandom_range(0, 19);
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        n_sent++;
        // keep a copy of the polygon for picking query points
        if (cmd == CMD_LOAD) begin
            if (fresh) begin
                poly_x.delete();
                poly_y.delete();
            end
            if (poly_x.size() < MAX_VERTICES) begin
                poly_x = {poly_x, x};
                poly_y = {poly_y, y};
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering words until every answer is back
    task automatic drain_results();
        if (start)
            start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic new_frame();
        int r;
        r = $urandom_range(0, 99);
        frame_mode = (r < 60) ? FRAME_GRID : (r < 85) ? FRAME_COARSE : FRAME_WIDE;
        frame_ox   = int'($urandom_range(0, 65470)) - 32735;
        frame_oy   = int'($urandom_range(0, 65470)) - 32735;
        quiet      = ($urandom_range(0, 3) == 0);
    endtask

    task automatic load_vertex(logic fresh);
        int x, y;
        x = frame_coord(frame_ox, 8);
        y = frame_coord(frame_oy, 8);
        send_word(CMD_LOAD, fresh, x, y);
    endtask

    // query at a vertex, near an edge midpoint, in the frame, or anywhere
    task automatic ask_point();
        int r, k, k2, x, y;
        r = $urandom_range(0, 99);
        if (poly_x.size() > 0 && r < 25) begin
            k = $urandom_range(0, poly_x.size() - 1);
            x = poly_x[k];
            y = poly_y[k];
        end else if (poly_x.size() > 0 && r < 45) begin
            k  = $urandom_range(0, poly_x.size() - 1);
            k2 = (k + 1) % poly_x.size();
            x  = (poly_x[k] + poly_x[k2]) >>> 1;
            y  = (poly_y[k] + poly_y[k2]) >>> 1;
        end else if (r < 90) begin
            x = frame_coord(frame_ox, 9);
            y = frame_coord(frame_oy, 9);
        end else begin
            x = int'($urandom_range(0, 65535)) - 32768;
            y = int'($urandom_range(0, 65535)) - 32768;
        end
        send_word(CMD_QUERY, 1'($urandom_range(0, 1)), x, y);
    endtask

    // one polygon with a handful of queries, plus some stray loads
    task automatic run_polygon();
        int r, n, q;
        new_frame();
        r = $urandom_range(0, 99);
        n = (r < 10) ? $urandom_range(1, 2) :
            (r < 97) ? $urandom_range(3, 12) : $urandom_range(100, 259);
        load_vertex(1'b1);
        for (int k = 1; k < n; k++)
            load_vertex($urandom_range(0, 19) == 0);
        q = $urandom_range(2, 10);
        for (int k = 0; k < q; k++) begin
            if ($urandom_range(0, 9) == 0)
                load_vertex(1'b0);
            else
                ask_point();
        end
        if ($urandom_range(0, 9) == 0)
            drain_results();
    endtask

    initial begin
        int fails;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_word  <= '0;
        quiet    = 1'b0;
        n_sent   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty polygon
        send_word(CMD_QUERY, 1'b0, 0, 0);
        send_word(CMD_QUERY, 1'b1, -32768, 32767);
        // one vertex, then two
        send_word(CMD_LOAD, 1'b1, 5, -5);
        send_word(CMD_QUERY, 1'b0, 5, -5);
        send_word(CMD_QUERY, 1'b0, 6, -5);
        send_word(CMD_LOAD, 1'b0, -3, 7);
        send_word(CMD_QUERY, 1'b0, 1, 1);
        send_word(CMD_QUERY, 1'b0, 1, 2);
        // square on the coordinate extremes
        send_word(CMD_LOAD, 1'b1, -32768, -32768);
        send_word(CMD_LOAD, 1'b0, 32767, -32768);
        send_word(CMD_LOAD, 1'b0, 32767, 32767);
        send_word(CMD_LOAD, 1'b0, -32768, 32767);
        send_word(CMD_QUERY, 1'b0, 0, 0);
        send_word(CMD_QUERY, 1'b0, -32768, 0);
        send_word(CMD_QUERY, 1'b0, 32767, 32767);
        send_word(CMD_QUERY, 1'b1, -32768, -32768);
        // concave shape, one query on the line through the notch vertex
        send_word(CMD_LOAD, 1'b1, 0, 0);
        send_word(CMD_LOAD, 1'b0, 10, 0);
        send_word(CMD_LOAD, 1'b0, 10, 10);
        send_word(CMD_LOAD, 1'b0, 5, 3);
        send_word(CMD_LOAD, 1'b0, 0, 10);
        send_word(CMD_QUERY, 1'b0, 5, 5);
        send_word(CMD_QUERY, 1'b0, 5, 1);
        send_word(CMD_QUERY, 1'b0, 2, 5);
        send_word(CMD_QUERY, 1'b0, -1, 3);
        drain_results();

        // fill to capacity, overflow, then restart on a full polygon
        new_frame();
        frame_mode = FRAME_COARSE;
        quiet      = 1'b1;
        load_vertex(1'b1);
        for (int k = 1; k < MAX_VERTICES + 3; k++)
            load_vertex(1'b0);
        quiet = 1'b0;
        repeat (3) ask_point();
        load_vertex(1'b1);
        repeat (2) ask_point();
        drain_results();

        // random polygons and queries
        while (n_sent < 1200)
            run_polygon();

        drain_results();
        repeat (20) @(posedge i_clk);
        fails = sb.n_bad + sb.pending();
        if (sb.pending() != 0)
            $display("%0d answers never arrived", sb.pending());
        $display("Covered %0d vertex loads (%0d past capacity) and %0d point queries",
                 sb.n_loads, sb.n_dropped, sb.n_queries);
        $display("Answers: %0d outside, %0d on an edge, %0d inside; %0d mismatches",
                 sb.n_loc[LOC_OUTSIDE], sb.n_loc[LOC_ON], sb.n_loc[LOC_INSIDE], sb.n_bad);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #50_000_000;
        $display("Timed out with %0d answers outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pip_pkg.sv
rtl/pip_ram.sv
rtl/pip_edge.sv
rtl/point_in_polygon_test.sv
rtl/pip_checker.sv
tb/tb_top.sv
